### rtl/brr_pkg.sv
// Shared types and constants for the block reverse reorder design.
// No dependencies; every other file but brr_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

  localparam int VAL_W = 32;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] GROUP_RESET = 5'd2;

  // One run handed from the front to the back
  typedef struct packed {
    logic             bank;
    logic [CFG_W-1:0] count;
    logic             reverse;
    logic             seq_end;
  } desc_t;

  // Back tells the front that a bank has been read out
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

`default_nettype wire

### rtl/block_reverse_reorder.sv
// Block reverse reorder: a closed run goes through the descriptor queue, the RAM read
// register and the output register; then one result per cycle while out_ready is high.
// Input takes one word per cycle within a run; after posting a run the front holds,
// if the next bank is still busy, until that bank's last read is issued.
// Reset (rst, synchronous): empties the queue and both banks, group_size back
// to 2; buffer contents are left as they were.
`timescale 1ns / 1ps
`default_nettype none

module block_reverse_reorder
  import brr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [VAL_W-1:0] item_value,
  input  wire logic                    final_item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_value,
  output logic                         run_end,
  output logic                         sequence_end
);

  // Two banks of MAX_GROUP words each, in one RAM
  localparam int DEPTH = 2 * MAX_GROUP;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0] group_size;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  logic     push;
  desc_t    push_desc;
  logic     q_pop;
  logic     q_valid;
  desc_t    q_desc;
  release_t bank_release;

  // Group size register; the user must write it only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_RESET;
    end else if (cfg_write) begin
      group_size <= cfg_data;
    end
  end

  // Front: take words, fill the current bank, post runs
  brr_front #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .group_size   (group_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .item_value   (item_value),
    .final_item   (final_item),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_desc    (push_desc),
    .bank_release (bank_release)
  );

  // Hold at most one descriptor per bank
  brr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (q_desc)
  );

  // Ping-pong word buffer
  brr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back: drain each run in order, reversed for full groups
  brr_back #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_desc       (q_desc),
    .q_pop        (q_pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .bank_release (bank_release),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .run_end      (run_end),
    .sequence_end (sequence_end)
  );

endmodule

`default_nettype wire

### rtl/brr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module brr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/brr_front.sv
// Front end: accepts words, writes them into the current bank, and posts
// a run descriptor when a group completes or the sequence ends. Uses brr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brr_front
  import brr_pkg::*;
#(
  parameter int MAX_GROUP = 16,
  parameter int AW        = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [CFG_W-1:0]        group_size,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [VAL_W-1:0] item_value,
  input  wire logic                    final_item,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [VAL_W-1:0]             wr_data,
  output logic                         push,
  output desc_t                        push_desc,
  input  wire release_t                bank_release
);

  logic [CFG_W-1:0] fill;
  logic [CFG_W-1:0] fill_next;
  logic             bank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;
  logic [CFG_W-1:0] eff_group;
  logic [CFG_W-1:0] n;
  logic             accept;
  logic             done_group;
  logic [AW-1:0]    base;

  // Clamp the group size into 1..MAX_GROUP
  always_comb begin
    if (group_size == '0) begin
      eff_group = CFG_W'(1);
    end else if ({2'b00, group_size} > 7'(MAX_GROUP)) begin
      eff_group = CFG_W'(MAX_GROUP);
    end else begin
      eff_group = group_size;
    end
  end

  assign in_ready   = !busy[bank];
  assign accept     = in_valid && in_ready;
  assign n          = fill + CFG_W'(1);
  assign done_group = (n >= eff_group);
  assign base       = bank ? AW'(MAX_GROUP) : '0;

  assign wr_en   = accept;
  assign wr_addr = base + AW'(fill);
  assign wr_data = item_value;

  assign push              = accept && (done_group || final_item);
  assign push_desc.bank    = bank;
  assign push_desc.count   = n;
  assign push_desc.reverse = done_group;
  assign push_desc.seq_end = final_item;

  always_comb begin
    busy_next = busy;
    if (bank_release.valid) begin
      busy_next[bank_release.bank] = 1'b0;
    end
    if (push) begin
      busy_next[bank] = 1'b1;
    end
    fill_next = fill;
    if (push) begin
      fill_next = '0;
    end else if (accept) begin
      fill_next = n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
      busy <= '0;
    end else begin
      fill <= fill_next;
      busy <= busy_next;
      // Flip to the other bank once a run is posted
      if (push) begin
        bank <= !bank;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/brr_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Uses brr_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module brr_queue
  import brr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output logic       pop_valid,
  output desc_t      pop_desc
);

  desc_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign pop_valid = (count != 2'd0);
  assign pop_desc  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_desc;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/brr_back.sv
// Back end: walks one run descriptor at a time, reads its bank in forward
// or reverse order and presents the words through an output register. Uses brr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brr_back
  import brr_pkg::*;
#(
  parameter int MAX_GROUP = 16,
  parameter int AW        = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire desc_t            q_desc,
  output logic                  q_pop,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  wire logic [VAL_W-1:0] rd_data,
  output release_t              bank_release,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic                  run_end,
  output logic                  sequence_end
);

  logic             active;
  desc_t            desc;
  logic [CFG_W-1:0] idx;
  logic [CFG_W-1:0] offset;
  logic [AW-1:0]    base;
  logic             rv;
  logic             rv_last;
  logic             rv_seq;
  logic             load_out;
  logic             last_issue;

  assign load_out   = rv && (!out_valid || out_ready);
  assign rd_en      = active && (!rv || load_out);
  assign last_issue = rd_en && (idx == desc.count - CFG_W'(1));
  assign q_pop      = q_valid && (!active || last_issue);

  assign offset  = desc.reverse ? (desc.count - CFG_W'(1) - idx) : idx;
  assign base    = desc.bank ? AW'(MAX_GROUP) : '0;
  assign rd_addr = base + AW'(offset);

  // Free the bank once its last read is issued
  assign bank_release.valid = last_issue;
  assign bank_release.bank  = desc.bank;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc <= q_desc;
    end
    if (rd_en) begin
      rv_last <= last_issue;
      rv_seq  <= last_issue && desc.seq_end;
    end
    if (load_out) begin
      out_value    <= rd_data;
      run_end      <= rv_last;
      sequence_end <= rv_seq;
    end
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (last_issue) begin
        active <= 1'b0;
      end else if (rd_en) begin
        idx <= idx + CFG_W'(1);
      end
      if (rd_en) begin
        rv <= 1'b1;
      end else if (load_out) begin
        rv <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### test/tb_block_reverse_reorder.sv
// Testbench for block_reverse_reorder: directed and random word sequences,
// checked result by result against a group-reversal predictor kept alongside.
// Depends on brr_pkg (rtl/brr_pkg.sv) and the block itself.
`timescale 1ns / 1ps

module tb_block_reverse_reorder
  import brr_pkg::*;
();

  localparam int MAX_GROUP     = 16;
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 8;     // lets the block's registers empty, with margin
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 34;

  // One reordered word as it should leave the block
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    run_end;
    logic                    seq_end;
  } reordered_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [VAL_W-1:0] item_value;
  logic                    final_item;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_value;
  logic                    run_end;
  logic                    sequence_end;

  // Predictor state: words held for the current group and the written group size
  logic signed [VAL_W-1:0] group_held [MAX_GROUP];
  int                      held_count    = 0;
  logic [CFG_W-1:0]        group_setting = GROUP_RESET;

  reordered_t awaited_words [$];

  int error_count  = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int tx_idle_pct  = IDLE_PCT;
  int rx_idle_pct  = IDLE_PCT;
  int rx_hold_left = 0;

  block_reverse_reorder #(
    .MAX_GROUP(MAX_GROUP)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_value  (item_value),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .run_end     (run_end),
    .sequence_end(sequence_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Map the written register onto the group length actually used:
  // zero behaves as one, anything above the buffer depth saturates.
  function automatic int group_len(input logic [CFG_W-1:0] setting);
    if (setting == '0) return 1;
    if (setting > MAX_GROUP) return MAX_GROUP;
    return int'(setting);
  endfunction

  // Store one accepted word and queue whatever words it releases.
  // A full group (or more, after the size was lowered) comes out newest first;
  // a partial group closed by the final word keeps its arrival order.
  function automatic void reorder_word(input logic signed [VAL_W-1:0] value,
                                       input logic last_of_seq);
    int         glen;
    int         n;
    reordered_t r;
    glen = group_len(group_setting);
    if (held_count < MAX_GROUP) begin
      group_held[held_count] = value;
      held_count++;
    end
    n = held_count;
    if (n >= glen) begin
      for (int i = 0; i < n; i++) begin
        r.value   = group_held[n-1-i];
        r.run_end = (i == n - 1);
        r.seq_end = (i == n - 1) && last_of_seq;
        awaited_words.push_back(r);
      end
      held_count = 0;
    end else if (last_of_seq) begin
      for (int i = 0; i < n; i++) begin
        r.value   = group_held[i];
        r.run_end = (i == n - 1);
        r.seq_end = (i == n - 1);
        awaited_words.push_back(r);
      end
      held_count = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Offer one word; idle first at random, then hold valid and payload until taken.
  // Valid is left high on return so a following word can go out without a gap.
  task automatic send_word(input logic signed [VAL_W-1:0] value, input logic last_of_seq);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    item_value <= value;
    final_item <= last_of_seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reorder_word(value, last_of_seq);
    words_sent++;
  endtask

  // Write the group size only with the block idle: drop valid, let every
  // awaited word drain, then allow the pipeline to settle before the write.
  task automatic set_group(input logic [CFG_W-1:0] setting);
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    cfg_write     <= 1'b0;
    group_setting  = setting;
  endtask

  // Mostly random words, with the signed extremes, zero and minus one mixed in
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_group();
    if ($urandom_range(99) < 70) return CFG_W'($urandom_range(1, 5));
    case ($urandom_range(4))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(MAX_GROUP);
      3:       return CFG_W'($urandom_range(MAX_GROUP + 1, 31));
      default: return CFG_W'($urandom_range(6, MAX_GROUP - 1));
    endcase
  endfunction

  // Group size straight out of reset is two: pairs reverse, odd tail passes
  task automatic test_reset_default();
    send_word({1'b1, {(VAL_W-1){1'b0}}}, 1'b0);
    send_word({1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
    send_word('0, 1'b1);
  endtask

  // Zero in the register behaves as one: straight through
  task automatic test_zero_group();
    set_group('0);
    send_word('1, 1'b0);
    send_word(32'sd1, 1'b1);
  endtask

  // All-ones register saturates to the full depth; the group closes on the
  // final word, so the last reversed word carries the sequence end
  task automatic test_saturated_full_group();
    set_group('1);
    for (int i = 0; i < MAX_GROUP; i++) send_word(pick_value(), i == MAX_GROUP - 1);
  endtask

  // A partial group closed by the final word keeps its order
  task automatic test_partial_final();
    set_group(CFG_W'(5));
    for (int i = 0; i < 3; i++) send_word(pick_value(), i == 2);
  endtask

  // Lower the group size while words are held: the next word flushes all of them
  task automatic test_shrink_mid_group();
    set_group(CFG_W'(8));
    for (int i = 0; i < 5; i++) send_word(pick_value(), 1'b0);
    set_group(CFG_W'(3));
    send_word(pick_value(), 1'b0);
  endtask

  // Hold the receiver off while words keep coming, so both banks fill
  // and the input stalls; then release and let it all drain
  task automatic test_backpressure();
    set_group(CFG_W'(4));
    tx_idle_pct  = 0;
    rx_hold_left = 80;
    for (int i = 0; i < 24; i++) send_word(pick_value(), i == 23);
    tx_idle_pct = IDLE_PCT;
  endtask

  // Phases of well-formed sequences under random group sizes, sizes one and
  // full depth first; now and then a sequence is cut off without its final word
  task automatic test_random_sequences(input int word_target);
    int               first;
    int               phase;
    int               glen;
    int               len;
    bit               broken;
    logic [CFG_W-1:0] setting;
    first = words_sent;
    phase = 0;
    while (words_sent - first < word_target) begin
      case (phase)
        0:       setting = CFG_W'(1);
        1:       setting = CFG_W'(MAX_GROUP);
        default: setting = pick_group();
      endcase
      set_group(setting);
      glen = group_len(setting);
      repeat ($urandom_range(1, 3)) begin
        len    = $urandom_range(1, 2 * glen + 1);
        broken = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
          // Middle half runs with no idling on either side
          if (words_sent - first >= word_target / 4 &&
              words_sent - first < 3 * word_target / 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
          end else begin
            tx_idle_pct = IDLE_PCT;
            rx_idle_pct = IDLE_PCT;
          end
          send_word(pick_value(), (i == len - 1) && !broken);
        end
      end
      phase++;
    end
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  // Receiver: honour a pending hold-off first, otherwise idle at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare every accepted word with the oldest awaited one
  always @(posedge clk) begin
    reordered_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d", out_value));
      end else begin
        want = awaited_words.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("out_value %0d, wanted %0d", out_value, want.value));
        if (run_end !== want.run_end)
          report_mismatch($sformatf("run_end %b, wanted %b (value %0d)",
                                    run_end, want.run_end, want.value));
        if (sequence_end !== want.seq_end)
          report_mismatch($sformatf("sequence_end %b, wanted %b (value %0d)",
                                    sequence_end, want.seq_end, want.value));
      end
    end
  end

  // Watchdog: give up when neither side has moved a word for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words still awaited",
               STALL_LIMIT, awaited_words.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    item_value <= '0;
    final_item <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_zero_group();
    test_saturated_full_group();
    test_partial_final();
    test_shrink_mid_group();
    test_backpressure();
    test_random_sequences(46);

    // Drop valid, drain what is awaited, then watch a while for stray words
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words in, %0d words out, %0d mismatches", words_sent,
             results_seen, error_count);
    $display("group sizes 0 to 31 incl. saturation, mid-group shrink, back-pressure hold");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/brr_pkg.sv
rtl/brr_ram.sv
rtl/brr_front.sv
rtl/brr_queue.sv
rtl/brr_back.sv
rtl/block_reverse_reorder.sv
test/tb_block_reverse_reorder.sv
